>>> src/sfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int HEAD_W      = 64;
    localparam int TAIL_W      = 32;
    localparam int COUNT_W     = 16;

    typedef enum logic
    {
        OP_BYTE = 1'b0,
        OP_POLL = 1'b1
    } op_t;

    localparam logic [CFG_INDEX_W-1:0] REG_HEADER  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 2'd2;

    localparam logic [7:0]         HEADER_RESET  = 8'hA4;
    localparam logic [7:0]         ADDRESS_RESET = 8'h00;
    localparam logic [COUNT_W-1:0] TIMEOUT_RESET = 16'd5000;

    typedef struct packed
    {
        logic poll;
        logic frame;
    } link_ctl_t;

endpackage

`default_nettype wire

>>> src/sfr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink (input valid, input op, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> src/sfr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfr_out_if;
    logic                        valid;
    logic                        ready;
    logic                        frame_found;
    logic [sfr_pkg::HEAD_W-1:0]  frame_head;
    logic [sfr_pkg::TAIL_W-1:0]  frame_tail;
    logic                        poll_had_frame;
    logic                        link_mode;

    modport source (output valid, output frame_found, output frame_head, output frame_tail,
                    output poll_had_frame, output link_mode, input ready);
    modport sink (input valid, input frame_found, input frame_head, input frame_tail,
                  input poll_had_frame, input link_mode, output ready);
endinterface

`default_nettype wire

>>> src/sfr_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sfr_pkg::CFG_INDEX_W-1:0]  index;
    logic [sfr_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/sfr_window.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_window #(
    parameter int FRAME_BYTES = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift_en,
    input  logic [7:0]                 rx_byte,
    input  logic [7:0]                 header_byte,
    input  logic [7:0]                 station_address,
    output logic                       found,
    output logic [sfr_pkg::HEAD_W-1:0] frame_head,
    output logic [sfr_pkg::TAIL_W-1:0] frame_tail
);

    logic [7:0] window_reg  [FRAME_BYTES];
    logic [7:0] window_next [FRAME_BYTES];
    // sum of the newest FRAME_BYTES-1 bytes
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic       match;
    logic [sfr_pkg::HEAD_W-1:0] head_raw;
    logic [sfr_pkg::TAIL_W-1:0] tail_raw;

    genvar g;
    generate
        for (g = 0; g < FRAME_BYTES - 1; g++)
        begin : g_shift
            assign window_next[g] = window_reg[g + 1];
        end
    endgenerate
    assign window_next[FRAME_BYTES - 1] = rx_byte;

    assign sum_next = sum_reg - window_reg[1] + rx_byte;

    assign match = (window_reg[1] == header_byte) && (window_reg[2] == station_address)
                   && (sum_reg == rx_byte);
    assign found = shift_en && match;

    generate
        for (g = 0; g < 8; g++)
        begin : g_head
            if (g < FRAME_BYTES)
            begin : g_byte
                assign head_raw[8*g +: 8] = window_next[g];
            end
            else
            begin : g_zero
                assign head_raw[8*g +: 8] = 8'h00;
            end
        end
        for (g = 0; g < 4; g++)
        begin : g_tail
            if (g + 8 < FRAME_BYTES)
            begin : g_byte
                assign tail_raw[8*g +: 8] = window_next[g + 8];
            end
            else
            begin : g_zero
                assign tail_raw[8*g +: 8] = 8'h00;
            end
        end
    endgenerate

    assign frame_head = found ? head_raw : '0;
    assign frame_tail = found ? tail_raw : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= 8'h00;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                window_reg[i] <= 8'h00;
            end
        end
        else if (shift_en)
        begin
            sum_reg <= sum_next;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                window_reg[i] <= window_next[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> src/sfr_link.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_link (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sfr_pkg::link_ctl_t          ctl,
    input  logic [sfr_pkg::COUNT_W-1:0] timeout_polls,
    output logic                        had_frame,
    output logic                        link_mode
);

    logic                        pending_reg;
    logic                        pending_next;
    logic [sfr_pkg::COUNT_W-1:0] count_reg;
    logic [sfr_pkg::COUNT_W-1:0] count_next;
    logic                        link_reg;
    logic                        link_next;

    always_comb
    begin
        pending_next = pending_reg;
        count_next   = count_reg;
        link_next    = link_reg;
        had_frame    = 1'b0;
        if (ctl.frame)
        begin
            pending_next = 1'b1;
        end
        else if (ctl.poll)
        begin
            if (pending_reg)
            begin
                had_frame    = 1'b1;
                pending_next = 1'b0;
                count_next   = '0;
                link_next    = 1'b1;
            end
            else if (count_reg < timeout_polls)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                link_next = 1'b0;
            end
        end
    end

    assign link_mode = link_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            count_reg   <= '0;
            link_reg    <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            count_reg   <= count_next;
            link_reg    <= link_next;
        end
    end

endmodule

`default_nettype wire

>>> src/sliding_frame_receiver_with_timeout.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  beat
// item     in   op, rx_byte
// result   out  frame_found, frame_head, frame_tail, poll_had_frame, link_mode
// cfg      in   index, data (always ready)
//
// one item per cycle while the result is not stalled; a result is registered after its item beat
// in the input register, then in the result register
// a stalled result holds both stages; item.ready follows result.ready
// reset clears the byte window, pending flag, silence count and link mode,
// and loads the register defaults

module sliding_frame_receiver_with_timeout #(
    parameter int FRAME_BYTES = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    sfr_in_if.sink        item,
    sfr_out_if.source     result,
    sfr_cfg_if.sink       cfg
);

    logic                        s1_valid_reg;
    logic                        s1_op_reg;
    logic [7:0]                  s1_byte_reg;
    logic                        advance;
    logic                        s1_fire;
    logic                        shift_en;

    logic [7:0]                  header_reg;
    logic [7:0]                  address_reg;
    logic [sfr_pkg::COUNT_W-1:0] timeout_reg;

    logic                        found;
    logic [sfr_pkg::HEAD_W-1:0]  head;
    logic [sfr_pkg::TAIL_W-1:0]  tail;
    logic                        had_frame;
    logic                        link_mode;
    sfr_pkg::link_ctl_t          link_ctl;

    logic                        out_valid_reg;
    logic                        found_reg;
    logic [sfr_pkg::HEAD_W-1:0]  head_reg;
    logic [sfr_pkg::TAIL_W-1:0]  tail_reg;
    logic                        had_reg;
    logic                        link_reg;

    assign advance    = !out_valid_reg || result.ready;
    assign item.ready = !s1_valid_reg || advance;
    assign s1_fire    = s1_valid_reg && advance;
    assign shift_en   = s1_fire && (s1_op_reg == sfr_pkg::OP_BYTE);

    assign link_ctl.poll  = s1_fire && (s1_op_reg == sfr_pkg::OP_POLL);
    assign link_ctl.frame = found;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= sfr_pkg::HEADER_RESET;
            address_reg <= sfr_pkg::ADDRESS_RESET;
            timeout_reg <= sfr_pkg::TIMEOUT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sfr_pkg::REG_HEADER:  header_reg  <= cfg.data[7:0];
                sfr_pkg::REG_ADDRESS: address_reg <= cfg.data[7:0];
                sfr_pkg::REG_TIMEOUT: timeout_reg <= cfg.data[sfr_pkg::COUNT_W-1:0];
                default:              ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            s1_op_reg   <= item.op;
            s1_byte_reg <= item.rx_byte;
        end
    end

    sfr_window #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_window (
        .clk             (clk),
        .rst_n           (rst_n),
        .shift_en        (shift_en),
        .rx_byte         (s1_byte_reg),
        .header_byte     (header_reg),
        .station_address (address_reg),
        .found           (found),
        .frame_head      (head),
        .frame_tail      (tail)
    );

    sfr_link u_link (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (link_ctl),
        .timeout_polls (timeout_reg),
        .had_frame     (had_frame),
        .link_mode     (link_mode)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            found_reg <= found;
            head_reg  <= head;
            tail_reg  <= tail;
            had_reg   <= had_frame;
            link_reg  <= link_mode;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.frame_found    = found_reg;
    assign result.frame_head     = head_reg;
    assign result.frame_tail     = tail_reg;
    assign result.poll_had_frame = had_reg;
    assign result.link_mode      = link_reg;

    a_found_not_poll: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && found_reg |-> !had_reg)
        else $error("frame found and poll result in one beat");

    a_poll_links: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && had_reg |-> link_reg)
        else $error("poll with frame did not report linked");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> item.ready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int FRAME_LEN   = 12;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_LEN    = 80;

    // index with no register behind it
    localparam logic [sfr_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct
    {
        sfr_pkg::op_t op;
        logic [7:0]   data;
    } rx_item_t;

    typedef struct packed
    {
        logic                       found;
        logic [sfr_pkg::HEAD_W-1:0] head;
        logic [sfr_pkg::TAIL_W-1:0] tail;
        logic                       had;
        logic                       link;
    } rx_result_t;

    logic clk = 1'b0;
    logic rst_n;

    sfr_in_if  item_bus ();
    sfr_out_if result_bus ();
    sfr_cfg_if cfg_bus ();

    sliding_frame_receiver_with_timeout dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver-side copy of the block state
    logic [7:0]                  win [FRAME_LEN];
    logic                        pending;
    logic [sfr_pkg::COUNT_W-1:0] silence;
    logic                        link;
    logic [7:0]                  hdr_val;
    logic [7:0]                  addr_val;
    logic [sfr_pkg::COUNT_W-1:0] timeout_val;

    rx_item_t   tx_items [$];
    rx_result_t results_due [$];
    rx_result_t seen;
    rx_result_t want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int items_taken    = 0;
    int frames_found   = 0;
    int polls_with_frame = 0;
    int links_lost     = 0;
    int quiet_cycles   = 0;
    int hold_left      = 0;
    bit hold_go        = 1'b0;

    function automatic rx_result_t frame_rx_predict(sfr_pkg::op_t op, logic [7:0] b);
        rx_result_t r;
        logic [7:0] sum;
        int         i;
        r = '0;
        if (op == sfr_pkg::OP_BYTE)
        begin
            for (i = 0; i < FRAME_LEN - 1; i++)
                win[i] = win[i + 1];
            win[FRAME_LEN - 1] = b;
            sum = 8'd0;
            for (i = 0; i < FRAME_LEN - 1; i++)
                sum = sum + win[i];
            if (win[0] == hdr_val && win[1] == addr_val && sum == win[FRAME_LEN - 1])
            begin
                r.found = 1'b1;
                pending = 1'b1;
                frames_found++;
                for (i = 0; i < FRAME_LEN; i++)
                begin
                    if (i < 8)
                        r.head[8*i +: 8] = win[i];
                    else
                        r.tail[8*(i-8) +: 8] = win[i];
                end
            end
        end
        else if (pending)
        begin
            r.had   = 1'b1;
            pending = 1'b0;
            silence = '0;
            link    = 1'b1;
            polls_with_frame++;
        end
        else if (silence < timeout_val)
            silence = silence + 1'b1;
        else
        begin
            if (link)
                links_lost++;
            link = 1'b0;
        end
        r.link = link;
        return r;
    endfunction

    function automatic void report_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %h, got %h", name, exp_v, got_v);
        end
    endfunction

    // item driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_bus.valid   <= 1'b0;
            item_bus.op      <= sfr_pkg::OP_BYTE;
            item_bus.rx_byte <= 8'd0;
        end
        else
        begin
            if (item_bus.valid && item_bus.ready)
            begin
                results_due.push_back(frame_rx_predict(sfr_pkg::op_t'(item_bus.op),
                                                       item_bus.rx_byte));
                items_taken++;
            end
            if (!item_bus.valid || item_bus.ready)
            begin
                if (tx_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item_bus.valid   <= 1'b1;
                    item_bus.op      <= tx_items[0].op;
                    item_bus.rx_byte <= tx_items[0].data;
                    void'(tx_items.pop_front());
                end
                else
                begin
                    item_bus.valid   <= 1'b0;
                    item_bus.op      <= sfr_pkg::op_t'($urandom_range(1));
                    item_bus.rx_byte <= 8'($urandom_range(255));
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_go)
        begin
            hold_go   <= 1'b0;
            hold_left <= HOLD_LEN;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            result_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
            if (result_bus.valid && result_bus.ready)
            begin
                seen.found = result_bus.frame_found;
                seen.head  = result_bus.frame_head;
                seen.tail  = result_bus.frame_tail;
                seen.had   = result_bus.poll_had_frame;
                seen.link  = result_bus.link_mode;
                if (results_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat: %h", seen);
                end
                else
                begin
                    want = results_due.pop_front();
                    report_field("frame_found", want.found, seen.found);
                    report_field("frame_head", want.head, seen.head);
                    report_field("frame_tail", want.tail, seen.tail);
                    report_field("poll_had_frame", want.had, seen.had);
                    report_field("link_mode", want.link, seen.link);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic queue_byte(logic [7:0] b);
        rx_item_t it;
        it.op   = sfr_pkg::OP_BYTE;
        it.data = b;
        tx_items.push_back(it);
    endtask

    task automatic queue_poll();
        rx_item_t it;
        it.op   = sfr_pkg::OP_POLL;
        it.data = 8'($urandom_range(255));
        tx_items.push_back(it);
    endtask

    // fill_value below zero gives random payload
    task automatic queue_frame(int nbytes, bit corrupt, int fill_value);
        logic [7:0] fb [FRAME_LEN];
        logic [7:0] sum;
        int         i;
        fb[0] = hdr_val;
        fb[1] = addr_val;
        for (i = 2; i < FRAME_LEN - 1; i++)
            fb[i] = (fill_value < 0) ? 8'($urandom_range(255)) : 8'(fill_value);
        sum = 8'd0;
        for (i = 0; i < FRAME_LEN - 1; i++)
            sum = sum + fb[i];
        fb[FRAME_LEN - 1] = sum;
        if (corrupt)
        begin
            i = $urandom_range(FRAME_LEN - 1);
            fb[i] = fb[i] ^ 8'($urandom_range(1, 255));
        end
        for (i = 0; i < nbytes; i++)
            queue_byte(fb[i]);
    endtask

    task automatic queue_traffic(int n);
        int made;
        int pick;
        int k;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                queue_frame(FRAME_LEN, $urandom_range(4) == 0, -1);
                made += FRAME_LEN;
                if ($urandom_range(1))
                begin
                    queue_poll();
                    made++;
                end
            end
            else if (pick < 72)
            begin
                k = $urandom_range(1, 8);
                repeat (k) queue_poll();
                made += k;
            end
            else if (pick < 87)
            begin
                k = $urandom_range(1, 6);
                repeat (k) queue_byte(8'($urandom_range(255)));
                made += k;
            end
            else
            begin
                // broken frame, cut short
                k = $urandom_range(2, FRAME_LEN - 1);
                queue_frame(k, 1'b0, -1);
                made += k;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (tx_items.size() != 0 || item_bus.valid || results_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // leaves valid high; caller lowers it after the last write
    task automatic write_reg(logic [sfr_pkg::CFG_INDEX_W-1:0] idx,
                             logic [sfr_pkg::CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            sfr_pkg::REG_HEADER:  hdr_val     = val[7:0];
            sfr_pkg::REG_ADDRESS: addr_val    = val[7:0];
            sfr_pkg::REG_TIMEOUT: timeout_val = val;
            default:              ;
        endcase
    endtask

    task automatic set_regs(logic [sfr_pkg::CFG_DATA_W-1:0] h,
                            logic [sfr_pkg::CFG_DATA_W-1:0] a,
                            logic [sfr_pkg::CFG_DATA_W-1:0] t);
        write_reg(sfr_pkg::REG_HEADER, h);
        write_reg(sfr_pkg::REG_ADDRESS, a);
        write_reg(sfr_pkg::REG_TIMEOUT, t);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic run_phase(int send_pct, int recv_pct, int n);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_traffic(n / 2);
        // sender pause until everything is back
        wait_drained();
        queue_traffic(n - n / 2);
        wait_drained();
    endtask

    initial
    begin
        item_bus.valid   = 1'b0;
        item_bus.op      = sfr_pkg::OP_BYTE;
        item_bus.rx_byte = 8'd0;
        result_bus.ready = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = '0;
        cfg_bus.data     = '0;
        rst_n            = 1'b0;
        for (int i = 0; i < FRAME_LEN; i++)
            win[i] = 8'd0;
        pending     = 1'b0;
        silence     = '0;
        link        = 1'b0;
        hdr_val     = sfr_pkg::HEADER_RESET;
        addr_val    = sfr_pkg::ADDRESS_RESET;
        timeout_val = sfr_pkg::TIMEOUT_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset values, field extremes, both ops
        queue_poll();
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_frame(FRAME_LEN, 1'b0, 8'hFF);
        queue_poll();
        queue_poll();
        queue_frame(FRAME_LEN, 1'b1, 8'h00);
        queue_poll();
        wait_drained();

        // masked upper bits and a short timeout; long receiver hold-off
        set_regs(16'hFFA4, 16'h015A, 16'd3);
        queue_traffic(200);
        hold_go = 1'b1;
        run_phase(0, 0, 200);

        // zero timeout, all-zero header and address
        set_regs(16'h0000, 16'h0000, 16'h0000);
        run_phase(67, 0, 400);

        set_regs(16'h00FF, 16'hFF00 | 16'h00FF, 16'hFFFF);
        run_phase(0, 67, 400);

        write_reg(sfr_pkg::REG_HEADER, 16'h007E);
        write_reg(sfr_pkg::REG_ADDRESS, 16'h0081);
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(sfr_pkg::REG_TIMEOUT, 16'd2);
        cfg_bus.valid <= 1'b0;
        run_phase(16, 16, 400);

        set_regs(16'($urandom_range(255)), 16'($urandom_range(255)), 16'd1);
        run_phase(0, 0, 400);

        repeat (8) @(posedge clk);
        if (results_due.size() != 0)
            errors += results_due.size();
        $display("covered %0d items over six register settings and four idle patterns",
                 items_taken);
        $display("%0d frames found, %0d polls saw a frame, %0d link losses, %0d mismatches",
                 frames_found, polls_with_frame, links_lost, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
